// ===== design/sliding_window_median_core_assert.svh =====
// Assertion macros for the sliding window median core.
// Needs a clock named aclk and an active-low reset named aresetn where used.
`ifndef SLIDING_WINDOW_MEDIAN_CORE_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/swm_pkg.sv =====
// Shared constants, types and helpers for the sliding window median core.
// No dependencies; used by swm_engine and sliding_window_median_core.
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SAMPLE_W   = 32;
    localparam int MEDIAN_W   = SAMPLE_W + 1;

    localparam logic [CNT_W-1:0] WSIZE_RESET = CNT_W'(3);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REM_RD,
        ST_REM_CMP,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_MED_A,
        ST_MED_B,
        ST_MED_C,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                sos;
    } job_t;

    typedef struct packed {
        logic                valid;
        logic [MEDIAN_W-1:0] median;
    } res_t;

    // A size of zero behaves as one, and anything above the store depth as the depth.
    function automatic logic [CNT_W-1:0] eff_window(input logic [CNT_W-1:0] ws);
        logic [CNT_W-1:0] w;
        w = ws;
        if (ws == '0) begin
            w = CNT_W'(1);
        end else if (ws > CNT_W'(WINDOW_MAX)) begin
            w = CNT_W'(WINDOW_MAX);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/sliding_window_median_core.sv =====
// Top level of the sliding window median core: handshakes, window size register
// and output register around swm_engine. Depends on swm_pkg and the assertion header.
//
//   Channel   Direction  Handshake            Word
//   s_        in         s_valid / s_ready    s_sample, s_start_of_sequence
//   m_        out        m_valid / m_ready    m_median_x2
//   cfg_      in         cfg_valid/cfg_ready  cfg_window_size
//
// A word that leaves the window full keeps the engine busy through these steps until it
// is ready again: a read and compare per entry to remove the leaving word, a read and shift
// per shifted entry for the insert, and reads of one or two middle entries for the median.
// A word into a filling window takes only the insert steps, and the median steps follow
// when it fills the window. Reset is synchronous and empties the window; the size
// returns to three. A result held in the output register does not block the next input
// word, but the engine waits in its final state while that register is still occupied.
`default_nettype none

`include "sliding_window_median_core_assert.svh"

module sliding_window_median_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [swm_pkg::SAMPLE_W-1:0]  s_sample,
    input  wire logic                          s_start_of_sequence,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [swm_pkg::MEDIAN_W-1:0]       m_median_x2,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [swm_pkg::CNT_W-1:0]     cfg_window_size
);
    import swm_pkg::*;

    logic [CNT_W-1:0]    wsize_reg, wsize_next;
    logic                m_valid_reg, m_valid_next;
    logic [MEDIAN_W-1:0] m_median_reg, m_median_next;

    logic [CNT_W-1:0]    w_eff;
    logic                eng_idle;
    logic                eng_start;
    logic                cfg_write;
    logic                out_free;
    job_t                eng_job;
    res_t                eng_res;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign w_eff     = eff_window(wsize_reg);
    assign s_ready   = eng_idle;
    assign eng_start = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign eng_job.sample = s_sample;
    assign eng_job.sos    = s_start_of_sequence;

    swm_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (eng_start),
        .job       (eng_job),
        .win       (w_eff),
        .clear     (cfg_write),
        .res_ready (out_free),
        .idle      (eng_idle),
        .res       (eng_res)
    );

    always_comb begin
        wsize_next    = wsize_reg;
        m_valid_next  = m_valid_reg;
        m_median_next = m_median_reg;
        if (cfg_write) begin
            wsize_next = cfg_window_size;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (eng_res.valid && out_free) begin
            m_valid_next  = 1'b1;
            m_median_next = eng_res.median;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg   <= WSIZE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            wsize_reg   <= wsize_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_median_reg <= m_median_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_median_x2 = m_median_reg;

    `SWM_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "engine idle after accepting a word")
    `SWM_ASSERT_NEXT(a_result_loaded, eng_res.valid && out_free, m_valid, "finished result not loaded")
    `SWM_ASSERT_NEXT(a_result_held, eng_res.valid && !out_free, eng_res.valid, "pending result dropped")
    `SWM_ASSERT_SAME(a_window_range, 1'b1, (w_eff != '0) && (w_eff <= CNT_W'(WINDOW_MAX)), "window size out of range")

endmodule

`default_nettype wire

// ===== design/swm_engine.sv =====
// Sequencer, arrival ring, sorted store and shared comparator of the median core.
// Depends on swm_pkg.
`default_nettype none

module swm_engine (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire swm_pkg::job_t              job,
    input  wire logic [swm_pkg::CNT_W-1:0]  win,
    input  wire logic                       clear,
    input  wire logic                       res_ready,
    output logic                            idle,
    output swm_pkg::res_t                   res
);
    import swm_pkg::*;

    logic [SAMPLE_W-1:0] arr_mem [WINDOW_MAX];
    logic [SAMPLE_W-1:0] srt_mem [WINDOW_MAX];

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                found_reg, found_next;
    logic                res_flag_reg, res_flag_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic [MEDIAN_W-1:0] med_reg, med_next;
    logic [SAMPLE_W-1:0] arr_rd_reg;
    logic [SAMPLE_W-1:0] srt_rd_reg;

    logic                arr_we;
    logic                srt_we;
    logic [IDX_W-1:0]    srt_waddr;
    logic [SAMPLE_W-1:0] srt_wdata;
    logic                srt_re;
    logic [IDX_W-1:0]    srt_raddr;

    logic [CNT_W-1:0]    fill_eff;
    logic [IDX_W-1:0]    ptr_eff;
    logic [CNT_W-1:0]    ptr_plus;
    logic [IDX_W-1:0]    ptr_wrap;
    logic                full_eff;
    logic [CNT_W-1:0]    idx_p1;
    logic [CNT_W-1:0]    idx_m1;
    logic [CNT_W-1:0]    half;
    logic [CNT_W-1:0]    half_m1;
    logic [SAMPLE_W-1:0] cmp_ref;
    logic                cmp_eq;
    logic                cmp_gt;
    state_t              finish_state;

    assign fill_eff = job.sos ? '0 : fill_reg;
    assign ptr_eff  = (job.sos || ({1'b0, ptr_reg} >= win)) ? '0 : ptr_reg;
    assign ptr_plus = {1'b0, ptr_eff} + CNT_W'(1);
    assign ptr_wrap = (ptr_plus >= win) ? '0 : ptr_plus[IDX_W-1:0];
    assign full_eff = (fill_eff >= win);
    assign idx_p1   = idx_reg + CNT_W'(1);
    assign idx_m1   = idx_reg - CNT_W'(1);
    assign half     = win >> 1;
    assign half_m1  = half - CNT_W'(1);

    // One comparator serves both the search for the leaving word and the insert.
    assign cmp_ref = (state_reg == ST_REM_CMP) ? arr_rd_reg : sample_reg;
    assign cmp_eq  = (srt_rd_reg == cmp_ref);
    assign cmp_gt  = ($signed(srt_rd_reg) > $signed(cmp_ref));

    assign finish_state = res_flag_reg ? ST_MED_A : ST_IDLE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            ptr_reg      <= '0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            res_flag_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            ptr_reg      <= ptr_next;
            idx_reg      <= idx_next;
            found_reg    <= found_next;
            res_flag_reg <= res_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        med_reg    <= med_next;
    end

    always_ff @(posedge aclk) begin
        if (arr_we) begin
            arr_rd_reg       <= arr_mem[ptr_eff];
            arr_mem[ptr_eff] <= job.sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (srt_we) begin
            srt_mem[srt_waddr] <= srt_wdata;
        end
        if (srt_re) begin
            srt_rd_reg <= srt_mem[srt_raddr];
        end
    end

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        ptr_next      = ptr_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        res_flag_next = res_flag_reg;
        sample_next   = sample_reg;
        med_next      = med_reg;
        arr_we        = 1'b0;
        srt_we        = 1'b0;
        srt_waddr     = idx_reg[IDX_W-1:0];
        srt_wdata     = sample_reg;
        srt_re        = 1'b0;
        srt_raddr     = idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    sample_next   = job.sample;
                    arr_we        = 1'b1;
                    ptr_next      = ptr_wrap;
                    res_flag_next = full_eff || ((fill_eff + CNT_W'(1)) == win);
                    if (full_eff) begin
                        fill_next  = win;
                        idx_next   = '0;
                        found_next = 1'b0;
                        state_next = ST_REM_RD;
                    end else begin
                        fill_next  = fill_eff + CNT_W'(1);
                        idx_next   = fill_eff;
                        state_next = ST_INS_CHK;
                    end
                end
            end
            ST_REM_RD: begin
                srt_re     = 1'b1;
                state_next = ST_REM_CMP;
            end
            ST_REM_CMP: begin
                if (found_reg) begin
                    srt_we    = 1'b1;
                    srt_waddr = idx_m1[IDX_W-1:0];
                    srt_wdata = srt_rd_reg;
                end else if (cmp_eq) begin
                    found_next = 1'b1;
                end
                if (idx_p1 == win) begin
                    idx_next   = win - CNT_W'(1);
                    state_next = ST_INS_CHK;
                end else begin
                    idx_next   = idx_p1;
                    state_next = ST_REM_RD;
                end
            end
            ST_INS_CHK: begin
                if (idx_reg == '0) begin
                    srt_we     = 1'b1;
                    state_next = finish_state;
                end else begin
                    srt_re     = 1'b1;
                    srt_raddr  = idx_m1[IDX_W-1:0];
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP: begin
                srt_we = 1'b1;
                if (cmp_gt) begin
                    srt_wdata  = srt_rd_reg;
                    idx_next   = idx_m1;
                    state_next = ST_INS_CHK;
                end else begin
                    state_next = finish_state;
                end
            end
            ST_MED_A: begin
                srt_re     = 1'b1;
                srt_raddr  = half[IDX_W-1:0];
                state_next = ST_MED_B;
            end
            ST_MED_B: begin
                if (win[0]) begin
                    med_next   = {srt_rd_reg, 1'b0};
                    state_next = ST_DONE;
                end else begin
                    med_next   = {srt_rd_reg[SAMPLE_W-1], srt_rd_reg};
                    srt_re     = 1'b1;
                    srt_raddr  = half_m1[IDX_W-1:0];
                    state_next = ST_MED_C;
                end
            end
            ST_MED_C: begin
                med_next   = med_reg + {srt_rd_reg[SAMPLE_W-1], srt_rd_reg};
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear) begin
            fill_next = '0;
            ptr_next  = '0;
        end
    end

    assign idle       = (state_reg == ST_IDLE);
    assign res.valid  = (state_reg == ST_DONE);
    assign res.median = med_reg;

endmodule

`default_nettype wire
